@@ rtl/are_pkg.sv @@
// ----------------------------------------------------------------------------
// are_pkg
// Types and constants for the adaptive range encoder.
// ----------------------------------------------------------------------------
package are_pkg;

  localparam int unsigned FREQ_W   = 17;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MAX_NORM = 4;

  localparam logic [WORD_W-1:0] TOP_LIMIT   = 32'h0001_0000;
  localparam logic [WORD_W-1:0] RANGE_RESET = 32'hffff_ffff;
  localparam logic [7:0]        CARRY_BYTE  = 8'hff;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_DIV,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_INC,
    S_CHK,
    S_RSC,
    S_NORM,
    S_FLUSH
  } are_state_t;

endpackage

@@ rtl/are_if.sv @@
// ----------------------------------------------------------------------------
// are_in_if / are_out_if
// Valid/ready channels for symbol items and output byte items.
// ----------------------------------------------------------------------------
interface are_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] symbol;

  modport source (output valid, output req_type, output symbol, input ready);
  modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

interface are_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/are_div.sv @@
// ----------------------------------------------------------------------------
// are_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module are_div
  import are_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [FREQ_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic [WORD_W-1:0] dvd_r;
  logic [FREQ_W-1:0] dsr_r;
  logic [FREQ_W-1:0] rem_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [FREQ_W:0]   sh;
  logic              qbit;
  logic [FREQ_W:0]   diff;

  always_comb begin
    sh   = {rem_r, dvd_r[WORD_W-1]};
    diff = sh - {1'b0, dsr_r};
    qbit = (sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[FREQ_W-1:0] : sh[FREQ_W-1:0];
        dvd_r <= {dvd_r[WORD_W-2:0], qbit};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ rtl/are_freq_mem.sv @@
// ----------------------------------------------------------------------------
// are_freq_mem
// Cumulative frequency store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module are_freq_mem
  import are_pkg::*;
#(
  parameter int unsigned DEPTH = 257,
  parameter int unsigned AW    = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [FREQ_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [FREQ_W-1:0] rdata
);

  logic [FREQ_W-1:0] mem [DEPTH];
  logic [FREQ_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/adaptive_range_encoder.sv @@
// ----------------------------------------------------------------------------
// adaptive_range_encoder
// Adaptive order-0 carryless 32-bit range encoder for byte symbols.
// ----------------------------------------------------------------------------
// Encode item: reads the table, divides, multiplies, sweeps the table from
//   symbol + 1 to the last entry, sweeps the whole table again on rescale,
//   then emits up to MAX_NORM bytes (possibly none), stalled by the output.
// Paced by the single divider and the one-entry-a-cycle table sweep.
// Flush item: emits the four bytes of low, top byte first, stalled by the output. One item in flight at a time.
// After reset the table is loaded in S_CLR; in_ready is low until it is done.
module adaptive_range_encoder
  import are_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 257
) (
  input  logic      clk,
  input  logic      rst_n,
  are_in_if.sink    in_ch,
  are_out_if.source out_ch
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  are_state_t        state_r, state_nxt;
  logic [WORD_W-1:0] low_r, low_nxt;
  logic [WORD_W-1:0] range_r, range_nxt;
  logic [FREQ_W-1:0] total_r, total_nxt;
  logic [FREQ_W-1:0] c0_r, c0_nxt;
  logic [FREQ_W-1:0] c1_r, c1_nxt;
  logic [WORD_W-1:0] q_r, q_nxt;
  logic [WORD_W-1:0] prod_r, prod_nxt;
  logic [IW-1:0]     sym_r, sym_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              stg_v_r, stg_v_nxt;
  logic [IW-1:0]     stg_a_r, stg_a_nxt;
  logic [FREQ_W-1:0] prev_r, prev_nxt;
  logic [2:0]        n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [FREQ_W-1:0] mem_wdata;
  logic [IW-1:0]     mem_raddr;
  logic [FREQ_W-1:0] mem_rdata;

  logic              div_start;
  logic [FREQ_W-1:0] div_divisor;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  logic [WORD_W-1:0] mul_a;
  logic [FREQ_W-1:0] mul_b;
  logic [WORD_W+FREQ_W-1:0] mul_p;

  logic              slot_free;
  logic [WORD_W:0]   carry_sum;
  logic [WORD_W-1:0] rng_clip;
  logic [WORD_W-1:0] rng_shift;
  logic [FREQ_W-1:0] half;
  logic [FREQ_W-1:0] rsc_val;

  are_freq_mem #(.DEPTH(TABLE_ENTRIES), .AW(IW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  are_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(range_r),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  assign mul_p       = mul_a * mul_b;
  assign div_divisor = (total_r == '0) ? FREQ_W'(1) : total_r;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign carry_sum   = {1'b0, range_r} + {17'd0, low_r[15:0]};
  assign half        = {1'b0, mem_rdata[FREQ_W-1:1]};
  assign rsc_val     = (stg_a_r == '0) ? half :
                       ((half <= prev_r) ? prev_r + FREQ_W'(1) : half);

  always_comb begin
    if (low_r[23:16] == CARRY_BYTE && carry_sum >= {1'b0, TOP_LIMIT}) begin
      rng_clip = TOP_LIMIT - {16'd0, low_r[15:0]};
    end else begin
      rng_clip = range_r;
    end
    rng_shift = {rng_clip[WORD_W-9:0], 8'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      low_r       <= '0;
      range_r     <= RANGE_RESET;
      total_r     <= FREQ_W'(TABLE_ENTRIES - 1);
      ptr_r       <= '0;
      iss_done_r  <= 1'b0;
      stg_v_r     <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      range_r     <= range_nxt;
      total_r     <= total_nxt;
      ptr_r       <= ptr_nxt;
      iss_done_r  <= iss_done_nxt;
      stg_v_r     <= stg_v_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    q_r        <= q_nxt;
    prod_r     <= prod_nxt;
    sym_r      <= sym_nxt;
    stg_a_r    <= stg_a_nxt;
    prev_r     <= prev_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    range_nxt     = range_r;
    total_nxt     = total_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    sym_nxt       = sym_r;
    ptr_nxt       = ptr_r;
    iss_done_nxt  = iss_done_r;
    stg_v_nxt     = 1'b0;
    stg_a_nxt     = stg_a_r;
    prev_nxt      = prev_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = stg_a_r;
    mem_wdata     = mem_rdata + FREQ_W'(1);
    mem_raddr     = ptr_r;
    div_start     = 1'b0;
    mul_a         = q_r;
    mul_b         = c0_r;
    in_ch.ready   = 1'b0;

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = FREQ_W'(ptr_r);
        if (ptr_r == LAST) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        sym_nxt     = IW'(in_ch.symbol);
        if (in_ch.valid) begin
          n_nxt = '0;
          if (in_ch.req_type == REQ_FLUSH) begin
            state_nxt = S_FLUSH;
          end else if ({1'b0, in_ch.symbol} < 9'(TABLE_ENTRIES - 1)) begin
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: begin
        mem_raddr = sym_r;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        c0_nxt    = mem_rdata;
        mem_raddr = sym_r + IW'(1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        c1_nxt    = mem_rdata;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_q;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_nxt  = mul_p[WORD_W-1:0];
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        low_nxt   = low_r + prod_r;
        mul_b     = c1_r - c0_r;
        prod_nxt  = mul_p[WORD_W-1:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        range_nxt    = prod_r;
        ptr_nxt      = sym_r + IW'(1);
        iss_done_nxt = 1'b0;
        state_nxt    = S_INC;
      end
      S_INC, S_RSC: begin
        if (!iss_done_r) begin
          stg_v_nxt = 1'b1;
          stg_a_nxt = ptr_r;
          if (ptr_r == LAST) begin
            iss_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + IW'(1);
          end
        end
        if (state_r == S_RSC) begin
          mem_wdata = rsc_val;
        end
        if (stg_v_r) begin
          mem_we   = 1'b1;
          prev_nxt = mem_wdata;
          if (stg_a_r == LAST) begin
            total_nxt = mem_wdata;
          end
        end
        if (iss_done_r && !stg_v_r) begin
          state_nxt = (state_r == S_INC) ? S_CHK : S_NORM;
        end
      end
      S_CHK: begin
        ptr_nxt      = '0;
        iss_done_nxt = 1'b0;
        state_nxt    = ({15'd0, total_r} >= TOP_LIMIT) ? S_RSC : S_NORM;
      end
      S_NORM: begin
        if (range_r >= TOP_LIMIT || n_r == 3'(MAX_NORM)) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = low_r[31:24];
          out_last_nxt  = !(rng_shift < TOP_LIMIT && n_r + 3'd1 < 3'(MAX_NORM));
          low_nxt       = {low_r[23:0], 8'd0};
          range_nxt     = rng_shift;
          n_nxt         = n_r + 3'd1;
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = low_r[31:24];
          out_last_nxt  = (n_r == 3'(MAX_NORM - 1));
          low_nxt       = {low_r[23:0], 8'd0};
          n_nxt         = n_r + 3'd1;
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

endmodule

@@ rtl/are_checker.sv @@
// ----------------------------------------------------------------------------
// are_checker
// Port-level checks for the adaptive range encoder.
// ----------------------------------------------------------------------------
module are_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("outputs not cleared by reset");

endmodule

bind adaptive_range_encoder are_checker u_are_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_byte (out_ch.out_byte),
  .out_last (out_ch.last)
);
